// ----- rtl/gpbfs_pkg.sv -----
package gpbfs_pkg;

    // default grid dimensions
    localparam int X_SIZE_DEF = 16;
    localparam int Y_SIZE_DEF = 16;
    localparam int Z_SIZE_DEF = 8;

    // largest reported hop count
    localparam logic [10:0] HOP_MAX = 11'd2047;

    // request codes
    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_EXISTS = 3'd2;
    localparam logic [2:0] REQ_MASK   = 3'd3;
    localparam logic [2:0] REQ_REACH  = 3'd4;
    localparam logic [2:0] REQ_CLEAR  = 3'd5;

    // request item
    typedef struct packed {
        logic [2:0] req_type;
        logic [3:0] x_pos;
        logic [3:0] y_pos;
        logic [2:0] z_pos;
        logic [3:0] to_x;
        logic [3:0] to_y;
        logic [2:0] to_z;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        ok;
        logic [10:0] hop_distance;
        logic [11:0] neighbour_mask;
    } t_out_item;

endpackage

// ----- rtl/grid_path_graph_bfs_engine_top.sv -----
// add, remove and exists: the cell is read in S_A_WAIT, then S_DONE; a cell off the grid goes straight to S_DONE
// neighbour mask: one cell store read per neighbour slot
// reach: visited bits are cleared, then cells are expanded breadth first; equal ends finish without a search
// clear: one store entry written per cycle; any output wait holds every request in S_DONE
// one request at a time; after reset a pass over every cell clears the store, ready stays low
// a new request is taken while the previous result still waits in the output register
module grid_path_graph_bfs_engine_top
    import gpbfs_pkg::*;
#(
    parameter int X_SIZE = X_SIZE_DEF,
    parameter int Y_SIZE = Y_SIZE_DEF,
    parameter int Z_SIZE = Z_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CELLS = X_SIZE * Y_SIZE * Z_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int HW    = AW;
    localparam int XW    = $clog2(X_SIZE);
    localparam int YW    = $clog2(Y_SIZE);
    localparam int ZW    = $clog2(Z_SIZE);

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [ZW-1:0] z;
        logic [HW-1:0] hops;
    } t_qent;

    typedef struct packed {
        logic          ok;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [ZW-1:0] z;
    } t_nbr;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_WAIT, S_B_WAIT, S_VCLR, S_SEED, S_POP,
        S_CUR, S_SCAN, S_CLR, S_DONE
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                                input logic [YW-1:0] y,
                                                input logic [ZW-1:0] z);
        return AW'(AW'(z) * AW'(X_SIZE * Y_SIZE)) + AW'(AW'(y) * AW'(X_SIZE)) + AW'(x);
    endfunction

    // neighbour in slot k: direction k/3 in order +x,-x,+y,-y, height step k%3-1
    function automatic t_nbr neighbour(input t_qent c, input logic [3:0] k);
        t_nbr       n;
        logic [1:0] dir;
        logic [1:0] dzc;
        n     = '{ok: 1'b1, x: c.x, y: c.y, z: c.z};
        dir   = 2'd0;
        dzc   = 2'd0;
        unique case (k)
            4'd0:  begin dir = 2'd0; dzc = 2'd0; end
            4'd1:  begin dir = 2'd0; dzc = 2'd1; end
            4'd2:  begin dir = 2'd0; dzc = 2'd2; end
            4'd3:  begin dir = 2'd1; dzc = 2'd0; end
            4'd4:  begin dir = 2'd1; dzc = 2'd1; end
            4'd5:  begin dir = 2'd1; dzc = 2'd2; end
            4'd6:  begin dir = 2'd2; dzc = 2'd0; end
            4'd7:  begin dir = 2'd2; dzc = 2'd1; end
            4'd8:  begin dir = 2'd2; dzc = 2'd2; end
            4'd9:  begin dir = 2'd3; dzc = 2'd0; end
            4'd10: begin dir = 2'd3; dzc = 2'd1; end
            4'd11: begin dir = 2'd3; dzc = 2'd2; end
            default: n.ok = 1'b0;
        endcase
        unique case (dir)
            2'd0: begin
                if (c.x == XW'(X_SIZE - 1)) n.ok = 1'b0;
                n.x = c.x + XW'(1);
            end
            2'd1: begin
                if (c.x == '0) n.ok = 1'b0;
                n.x = c.x - XW'(1);
            end
            2'd2: begin
                if (c.y == YW'(Y_SIZE - 1)) n.ok = 1'b0;
                n.y = c.y + YW'(1);
            end
            default: begin
                if (c.y == '0) n.ok = 1'b0;
                n.y = c.y - YW'(1);
            end
        endcase
        if (dzc == 2'd0) begin
            if (c.z == '0) n.ok = 1'b0;
            n.z = c.z - ZW'(1);
        end else if (dzc == 2'd2) begin
            if (c.z == ZW'(Z_SIZE - 1)) n.ok = 1'b0;
            n.z = c.z + ZW'(1);
        end
        return n;
    endfunction

    function automatic logic [10:0] hop_sat(input logic [HW-1:0] h);
        logic [HW+10:0] wide;
        wide = (HW + 11)'(h);
        if (wide > (HW + 11)'(HOP_MAX)) return HOP_MAX;
        return 11'(h);
    endfunction

    t_state        r_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_head;
    logic [CW-1:0] r_tail;
    logic [3:0]    r_k;
    logic          r_pend_valid;
    logic [3:0]    r_pend_k;
    t_nbr          r_pend;
    logic          r_mask_mode;
    logic [11:0]   r_mask;
    logic [2:0]    r_req;
    logic [XW-1:0] r_ax, r_bx;
    logic [YW-1:0] r_ay, r_by;
    logic [ZW-1:0] r_az, r_bz;
    t_qent         r_cur;
    t_out_item     r_res;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_qent         r_queue [CELLS];
    t_qent         r_q_rdata;

    logic          m_we;
    logic [AW-1:0] m_waddr;
    logic [1:0]    m_wdata;
    logic [AW-1:0] m_raddr;
    logic [1:0]    m_rdata;
    logic          q_we;
    logic [AW-1:0] q_waddr;
    t_qent         q_wdata;
    t_nbr          nb;
    logic          take;
    logic [11:0]   n_mask;
    logic          a_in, b_in;
    logic [XW-1:0] in_ax, in_bx;
    logic [YW-1:0] in_ay, in_by;
    logic [ZW-1:0] in_az, in_bz;

    // cell store: occupied and visited bits
    gpbfs_cell_mem #(.DEPTH(CELLS), .AW(AW)) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // frontier queue, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[q_waddr] <= q_wdata;
        end
        r_q_rdata <= r_queue[r_head[AW-1:0]];
    end

    // request coordinates and grid range checks
    always_comb begin
        a_in  = (32'(i_in_item.x_pos) < X_SIZE) && (32'(i_in_item.y_pos) < Y_SIZE)
                && (32'(i_in_item.z_pos) < Z_SIZE);
        b_in  = (32'(i_in_item.to_x) < X_SIZE) && (32'(i_in_item.to_y) < Y_SIZE)
                && (32'(i_in_item.to_z) < Z_SIZE);
        in_ax = XW'(i_in_item.x_pos);
        in_ay = YW'(i_in_item.y_pos);
        in_az = ZW'(i_in_item.z_pos);
        in_bx = XW'(i_in_item.to_x);
        in_by = YW'(i_in_item.to_y);
        in_bz = ZW'(i_in_item.to_z);
    end

    // memory access control
    always_comb begin
        nb      = neighbour(r_cur, r_k);
        take    = r_pend_valid && m_rdata[1]
                  && (r_mask_mode || (!m_rdata[0] && (r_tail < CW'(CELLS))));
        n_mask  = r_mask | ((take && r_mask_mode) ? (12'd1 << r_pend_k) : 12'd0);
        m_we    = 1'b0;
        m_waddr = '0;
        m_wdata = '0;
        m_raddr = '0;
        q_we    = 1'b0;
        q_waddr = r_tail[AW-1:0];
        q_wdata = '{x: r_pend.x, y: r_pend.y, z: r_pend.z, hops: r_cur.hops + HW'(1)};
        unique case (r_state)
            S_IDLE: m_raddr = cell_addr(in_ax, in_ay, in_az);
            S_A_WAIT: begin
                m_raddr = cell_addr(r_bx, r_by, r_bz);
                m_waddr = cell_addr(r_ax, r_ay, r_az);
                if (r_req == REQ_ADD && !m_rdata[1]) begin
                    m_we    = 1'b1;
                    m_wdata = 2'b10;
                end
                if (r_req == REQ_REMOVE && m_rdata[1]) begin
                    m_we    = 1'b1;
                    m_wdata = 2'b00;
                end
            end
            S_VCLR: begin
                m_raddr = r_cnt[AW-1:0];
                m_waddr = AW'(r_cnt - CW'(1));
                m_wdata = {m_rdata[1], 1'b0};
                m_we    = (r_cnt != '0);
            end
            S_SEED: begin
                m_we    = 1'b1;
                m_waddr = cell_addr(r_ax, r_ay, r_az);
                m_wdata = 2'b11;
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '{x: r_ax, y: r_ay, z: r_az, hops: '0};
            end
            S_SCAN: begin
                m_raddr = cell_addr(nb.x, nb.y, nb.z);
                m_waddr = cell_addr(r_pend.x, r_pend.y, r_pend.z);
                m_wdata = 2'b11;
                if (take && !r_mask_mode) begin
                    m_we = 1'b1;
                    q_we = 1'b1;
                end
            end
            S_INIT, S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_cnt[AW-1:0];
                m_wdata = 2'b00;
            end
            default: ;
        endcase
    end

    // control sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_cnt        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_mask_mode  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    if (r_cnt == CW'(CELLS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_item.req_type;
                        r_ax  <= in_ax;
                        r_ay  <= in_ay;
                        r_az  <= in_az;
                        r_bx  <= in_bx;
                        r_by  <= in_by;
                        r_bz  <= in_bz;
                        r_res <= '0;
                        r_cnt <= '0;
                        unique case (i_in_item.req_type)
                            REQ_ADD, REQ_REMOVE, REQ_EXISTS, REQ_MASK:
                                r_state <= a_in ? S_A_WAIT : S_DONE;
                            REQ_REACH: r_state <= (a_in && b_in) ? S_A_WAIT : S_DONE;
                            REQ_CLEAR: r_state <= S_CLR;
                            default:   r_state <= S_DONE;
                        endcase
                    end
                end
                S_A_WAIT: begin
                    unique case (r_req)
                        REQ_ADD: begin
                            r_res.ok <= !m_rdata[1];
                            r_state  <= S_DONE;
                        end
                        REQ_REMOVE, REQ_EXISTS: begin
                            r_res.ok <= m_rdata[1];
                            r_state  <= S_DONE;
                        end
                        REQ_MASK: begin
                            if (m_rdata[1]) begin
                                r_cur        <= '{x: r_ax, y: r_ay, z: r_az, hops: '0};
                                r_k          <= '0;
                                r_pend_valid <= 1'b0;
                                r_mask_mode  <= 1'b1;
                                r_mask       <= '0;
                                r_state      <= S_SCAN;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        REQ_REACH: r_state <= m_rdata[1] ? S_B_WAIT : S_DONE;
                        default:   r_state <= S_DONE;
                    endcase
                end
                S_B_WAIT: begin
                    if (m_rdata[1]) begin
                        if (r_ax == r_bx && r_ay == r_by && r_az == r_bz) begin
                            r_res.ok <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= S_VCLR;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_VCLR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(CELLS)) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_head      <= '0;
                    r_tail      <= CW'(1);
                    r_mask_mode <= 1'b0;
                    r_state     <= S_POP;
                end
                S_POP: begin
                    if (r_head == r_tail) begin
                        r_state <= S_DONE;
                    end else begin
                        r_head  <= r_head + CW'(1);
                        r_state <= S_CUR;
                    end
                end
                S_CUR: begin
                    r_cur        <= r_q_rdata;
                    r_k          <= '0;
                    r_pend_valid <= 1'b0;
                    if (r_q_rdata.x == r_bx && r_q_rdata.y == r_by && r_q_rdata.z == r_bz) begin
                        r_res.ok           <= 1'b1;
                        r_res.hop_distance <= hop_sat(r_q_rdata.hops);
                        r_state            <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend_valid <= (r_k < 4'd12) && nb.ok;
                    r_pend       <= nb;
                    r_pend_k     <= r_k;
                    r_k          <= r_k + 4'd1;
                    r_mask       <= n_mask;
                    if (take && !r_mask_mode) begin
                        r_tail <= r_tail + CW'(1);
                    end
                    if (r_k == 4'd12) begin
                        if (r_mask_mode) begin
                            r_res.ok             <= 1'b1;
                            r_res.neighbour_mask <= n_mask;
                            r_state              <= S_DONE;
                        end else begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_CLR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(CELLS - 1)) begin
                        r_res.ok <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // queue pointers stay ordered and bounded
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_CUR || r_state == S_SCAN) |-> (r_head <= r_tail))
        else $error("queue head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= CW'(CELLS))
        else $error("queue tail beyond cell count");

    // a nonzero distance or mask only comes with success
    a_hops_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.hop_distance != '0) |-> o_out_item.ok)
        else $error("distance reported without success");

    a_mask_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.neighbour_mask != '0) |-> o_out_item.ok)
        else $error("mask reported without success");

    // a result register is loaded only from the done state
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");

endmodule

// ----- rtl/gpbfs_cell_mem.sv -----
module gpbfs_cell_mem
    import gpbfs_pkg::*;
#(
    parameter int DEPTH = X_SIZE_DEF * Y_SIZE_DEF * Z_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [1:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [1:0]    o_rdata
);

    // bit 1 occupied, bit 0 visited
    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata;

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
